// ===== rtl/olse_pkg.sv =====
// ----------------------------------------------------------------------------
// olse_pkg
// Shared types, field widths and operation/status codes for the ordered
// list shift engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olse_pkg;

    // Default list capacity
    localparam int LIST_DEPTH_DEF = 32;

    // Field widths of the request and response transfers
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 5;
    localparam int COUNT_W  = 6;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd5;
    localparam logic [FUNC_W-1:0] FN_FIND       = 3'd6;
    localparam logic [FUNC_W-1:0] FN_MODIFY     = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // Request transfer
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    // Response transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at the position, write the value there
        logic del;   // close the slot at the position
        logic wr;    // overwrite the entry at the position
    } t_cell_op;

endpackage : olse_pkg

`default_nettype wire

// ===== rtl/olse_cell.sv =====
// ----------------------------------------------------------------------------
// olse_cell
// One list slot: holds one entry, shifts to/from its neighbors on insert and
// erase, and registers a match flag for find.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olse_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6
) (
    input  wire logic                         i_clk,
    input  wire olse_pkg::t_cell_op           i_op,
    input  wire logic [IDX_W-1:0]             i_pos,
    input  wire logic [olse_pkg::VALUE_W-1:0] i_value,
    input  wire logic [olse_pkg::VALUE_W-1:0] i_left,
    input  wire logic [olse_pkg::VALUE_W-1:0] i_right,
    input  wire logic [CNT_W-1:0]             i_count,
    input  wire logic                         i_cmp,
    output logic [olse_pkg::VALUE_W-1:0]      o_entry,
    output logic                              o_hit
);
    import olse_pkg::*;

    localparam logic [IDX_W-1:0] K_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] K_CNT = CNT_W'(CELL_INDEX);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               r_hit;

    // Slot update: write at the position, take from the left above it on
    // insert, take from the right at and above it on erase
    always_comb begin
        n_entry = r_entry;
        if ((i_op.ins || i_op.wr) && (K_IDX == i_pos)) begin
            n_entry = i_value;
        end else if (i_op.ins && (K_IDX > i_pos)) begin
            n_entry = i_left;
        end else if (i_op.del && (K_IDX >= i_pos)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Match flag, only for slots below the count
    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_hit <= (r_entry == i_value) && (K_CNT < i_count);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule : olse_cell

`default_nettype wire

// ===== rtl/olse_first_hit.sv =====
// ----------------------------------------------------------------------------
// olse_first_hit
// Lowest-index encoder over the registered cell match flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olse_first_hit #(
    parameter int LIST_DEPTH = 32,
    parameter int IDX_W      = 5
) (
    input  wire logic [LIST_DEPTH-1:0] i_hits,
    output logic                       o_any,
    output logic [IDX_W-1:0]           o_idx
);
    import olse_pkg::*;

    logic [LIST_DEPTH-1:0] w_lowest;

    // Isolate the lowest set flag
    assign w_lowest = i_hits & (~i_hits + LIST_DEPTH'(1));
    assign o_any    = |i_hits;

    // One-hot to binary: OR of the indexes of the set flag
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            o_idx = o_idx | ({IDX_W{w_lowest[i]}} & IDX_W'(i));
        end
    end

endmodule : olse_first_hit

`default_nettype wire

// ===== rtl/ordered_list_shift_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_shift_engine
// Fixed-capacity ordered list of 32-bit words built as a row of cells.
// A response passes from the request transfer through stage A and the output
// register. Throughput: one request per cycle while the response side does not
// stall; every cell shifts or compares in the cycle the request is taken, and
// the find encoder runs in the next stage. Reset clears the entry count and
// both pipeline valids; entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_shift_engine #(
    parameter int LIST_DEPTH = olse_pkg::LIST_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire olse_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_stall,
    output olse_pkg::t_rsp       o_rsp
);
    import olse_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = CNT_W + POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    // Handshake
    logic w_req_xfer;
    logic w_a_adv;
    logic w_o_free;

    // Count and request decode
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CMP_W-1:0]    w_pos_x;
    logic [CMP_W-1:0]    w_cnt_x;
    logic [IDX_W+POS_W-1:0] w_pos_ext;
    logic [IDX_W+CNT_W-1:0] w_cnt_ext;
    logic                w_full;
    logic                w_empty;
    logic [STATUS_W-1:0] w_status;
    logic                w_ins;
    logic                w_del;
    logic                w_wr;
    logic                w_inc;
    logic                w_dec;
    logic [1:0]          w_psel;
    logic [IDX_W-1:0]    w_pos;
    t_cell_op            w_op;

    // Cell row
    logic [VALUE_W-1:0]    w_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_hits;

    // Stage A
    logic                r_a_valid;
    logic                r_a_find;
    logic [STATUS_W-1:0] r_a_status;
    logic [CNT_W-1:0]    r_a_count;
    logic                w_any;
    logic [IDX_W-1:0]    w_idx;
    logic [IDX_W+FOUND_W-1:0] w_idx_ext;
    logic [CNT_W+COUNT_W-1:0] w_acnt_ext;
    t_rsp                w_rsp;

    // Output stage
    logic r_o_valid;
    t_rsp r_o_rsp;

    localparam logic [1:0] PSEL_REQ   = 2'd0;
    localparam logic [1:0] PSEL_COUNT = 2'd1;
    localparam logic [1:0] PSEL_ZERO  = 2'd2;

    // Pipeline flow
    assign w_o_free    = !r_o_valid || !i_rsp_stall;
    assign w_a_adv     = r_a_valid && w_o_free;
    assign o_req_stall = r_a_valid && !w_o_free;
    assign w_req_xfer  = i_req_valid && !o_req_stall;

    // Widened copies for compares and index selection
    assign w_pos_x   = CMP_W'(i_req.position);
    assign w_cnt_x   = CMP_W'(r_count);
    assign w_pos_ext = {{IDX_W{1'b0}}, i_req.position};
    assign w_cnt_ext = {{IDX_W{1'b0}}, r_count};
    assign w_full    = (r_count == DEPTH_C);
    assign w_empty   = (r_count == '0);

    // Request decode: status and cell command
    always_comb begin
        w_status = ST_OK;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_wr     = 1'b0;
        w_inc    = 1'b0;
        w_dec    = 1'b0;
        w_psel   = PSEL_REQ;
        unique case (i_req.func)
            FN_PUSH_BACK: begin
                w_psel = PSEL_COUNT;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_inc = 1'b1;
                end
            end
            FN_PUSH_FRONT: begin
                w_psel = PSEL_ZERO;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_inc = 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_dec = 1'b1;
                end
            end
            FN_POP_FRONT: begin
                w_psel = PSEL_ZERO;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                    w_dec = 1'b1;
                end
            end
            FN_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_inc = 1'b1;
                end
            end
            FN_ERASE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_del = 1'b1;
                    w_dec = 1'b1;
                end
            end
            FN_FIND: begin
                w_status = ST_NOTFOUND;
            end
            FN_MODIFY: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_wr = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Target slot
    always_comb begin
        case (w_psel)
            PSEL_COUNT: w_pos = w_cnt_ext[IDX_W-1:0];
            PSEL_ZERO:  w_pos = '0;
            default:    w_pos = w_pos_ext[IDX_W-1:0];
        endcase
    end

    assign w_op.ins = w_req_xfer && w_ins;
    assign w_op.del = w_req_xfer && w_del;
    assign w_op.wr  = w_req_xfer && w_wr;

    // Entry count
    always_comb begin
        n_count = r_count;
        if (w_req_xfer && w_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_req_xfer && w_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells, each linked to its neighbors; the first cell's left input is the request value
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        olse_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_value (i_req.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_count (r_count),
            .i_cmp   (w_req_xfer),
            .o_entry (w_entry[g]),
            .o_hit   (w_hits[g])
        );
    end

    // Stage A: status and new count held while the match flags settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_req_xfer) begin
            r_a_valid <= 1'b1;
        end else if (w_a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_xfer) begin
            r_a_find   <= (i_req.func == FN_FIND);
            r_a_status <= w_status;
            r_a_count  <= n_count;
        end
    end

    // Lowest matching slot
    olse_first_hit #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W)
    ) u_first_hit (
        .i_hits (w_hits),
        .o_any  (w_any),
        .o_idx  (w_idx)
    );

    assign w_idx_ext  = {{FOUND_W{1'b0}}, w_idx};
    assign w_acnt_ext = {{COUNT_W{1'b0}}, r_a_count};

    // Response assembly
    always_comb begin
        w_rsp.status      = r_a_status;
        w_rsp.found_index = '0;
        w_rsp.entry_count = w_acnt_ext[COUNT_W-1:0];
        if (r_a_find && w_any) begin
            w_rsp.status      = ST_OK;
            w_rsp.found_index = w_idx_ext[FOUND_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_o_rsp <= w_rsp;
        end
    end

    assign o_rsp_valid = r_o_valid;
    assign o_rsp       = r_o_rsp;

endmodule : ordered_list_shift_engine

`default_nettype wire
